>>> sv/prts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prts_pkg: shared types and constants of the priority thread release scheduler
// Request, operation, run state and status codes, the command and result
// beats, and the selection node used by the tick comparator chain.
// ----------------------------------------------------------------------------
package prts_pkg;

    localparam int MAX_THREADS = 16;
    localparam int SLOT_W      = $clog2(MAX_THREADS);
    localparam int TICK_GROUPS = 4;
    localparam int GROUP_SIZE  = (MAX_THREADS + TICK_GROUPS - 1) / TICK_GROUPS;

    localparam int KEY_W  = 16;
    localparam int PRIO_W = 10;
    localparam int GEN_W  = 16;
    localparam int POUT_W = 11;
    localparam int REQ_W  = 3;
    localparam int STAT_W = 2;
    localparam int SEL_W  = GEN_W + PRIO_W;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 2;

    localparam int CMDQ_DEPTH = 2;
    localparam int RESQ_DEPTH = 2;

    localparam logic [PRIO_W-1:0] PRIO_MIN = PRIO_W'(1);
    localparam logic [PRIO_W-1:0] PRIO_MAX = PRIO_W'(1000);

    localparam logic [REQ_W-1:0] REQ_CREATE = 3'd0;
    localparam logic [REQ_W-1:0] REQ_BLOCK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_RESUME = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_TICK   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_GEN_FIRST   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_PRIO = 2'd2;

    localparam logic [1:0] SYNC_ALWAYS   = 2'd0;
    localparam logic [1:0] SYNC_ALL_WAIT = 2'd1;
    localparam logic [1:0] SYNC_NONE_RUN = 2'd2;

    localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_UNTRACKED = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL      = 2'd2;

    typedef enum logic [2:0] {
        OP_CREATE,
        OP_BLOCK,
        OP_RESUME,
        OP_REMOVE,
        OP_TICK,
        OP_QUERY,
        OP_NONE
    } t_op;

    typedef enum logic [1:0] {
        RUN_READY,
        RUN_RUNNING,
        RUN_WAITING
    } t_run;

    typedef struct packed {
        logic       gen_first;
        logic [1:0] sync_mode;
        logic       ign_prio;
    } t_cfg;

    typedef struct packed {
        t_op               op;
        logic [KEY_W-1:0]  key;
        logic [PRIO_W-1:0] prio;
    } t_cmd;

    typedef struct packed {
        logic                     grant_valid;
        logic [KEY_W-1:0]         grant_key;
        logic signed [POUT_W-1:0] priority_out;
        logic [STAT_W-1:0]        status;
    } t_result;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] idx;
        logic [SEL_W-1:0]  key;
    } t_node;

    // The right-hand node always comes later in slot order than the left one.
    function automatic t_node sel_combine(t_node l, t_node r, logic ign);
        logic take;
        take = r.valid && (!l.valid || (ign ? (r.key >= l.key) : (r.key > l.key)));
        return take ? r : l;
    endfunction

endpackage

>>> sv/prts_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prts_front: request intake and classification
// Decodes the request type, clamps the create priority and holds the
// classified commands in a short queue until the table side takes them.
// ----------------------------------------------------------------------------
module prts_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [prts_pkg::REQ_W-1:0]    i_req_type,
    input  logic [prts_pkg::KEY_W-1:0]    i_thread_key,
    input  logic [prts_pkg::PRIO_W-1:0]   i_new_priority,
    output logic                          o_cmd_valid,
    output prts_pkg::t_cmd                o_cmd,
    input  logic                          i_cmd_pop
);
    import prts_pkg::*;

    localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

    t_cmd             r_q [CMDQ_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    t_cmd w_cmd;
    logic w_push;
    logic w_pop;

    always_comb begin
        w_cmd.key  = i_thread_key;
        w_cmd.prio = i_new_priority;
        if (i_new_priority < PRIO_MIN) begin
            w_cmd.prio = PRIO_MIN;
        end else if (i_new_priority > PRIO_MAX) begin
            w_cmd.prio = PRIO_MAX;
        end
        unique case (i_req_type)
            REQ_CREATE: w_cmd.op = OP_CREATE;
            REQ_BLOCK:  w_cmd.op = OP_BLOCK;
            REQ_RESUME: w_cmd.op = OP_RESUME;
            REQ_REMOVE: w_cmd.op = OP_REMOVE;
            REQ_TICK:   w_cmd.op = OP_TICK;
            REQ_QUERY:  w_cmd.op = OP_QUERY;
            default:    w_cmd.op = OP_NONE;
        endcase
    end

    assign o_full      = (r_count == CNT_W'(CMDQ_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd];
    assign w_push      = i_push && !o_full;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_q[r_wr] <= w_cmd;
                r_wr <= (r_wr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + CNT_W'(w_push) - CNT_W'(w_pop);
        end
    end

endmodule

>>> sv/prts_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prts_back: thread table and request execution
// Holds the slot table, carries out each command, runs the two-step tick
// selection and queues the result beats for the consumer.
// ----------------------------------------------------------------------------
module prts_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  prts_pkg::t_cfg   i_cfg,
    input  logic             i_cmd_valid,
    input  prts_pkg::t_cmd   i_cmd,
    output logic             o_cmd_pop,
    output logic             o_empty,
    input  logic             i_pop,
    output prts_pkg::t_result o_res
);
    import prts_pkg::*;

    localparam int PTR_W = (RESQ_DEPTH > 1) ? $clog2(RESQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(RESQ_DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_TICK
    } t_state;

    t_state            r_state;
    logic              r_used [MAX_THREADS];
    logic [KEY_W-1:0]  r_key  [MAX_THREADS];
    t_run              r_run  [MAX_THREADS];
    logic [PRIO_W-1:0] r_prio [MAX_THREADS];
    logic [GEN_W-1:0]  r_gen  [MAX_THREADS];

    t_node             r_grp [TICK_GROUPS];
    logic              r_allow;

    t_result           r_rq [RESQ_DEPTH];
    logic [PTR_W-1:0]  r_rwr;
    logic [PTR_W-1:0]  r_rrd;
    logic [CNT_W-1:0]  r_rcount;

    logic              w_match_found;
    logic [SLOT_W-1:0] w_match_idx;
    logic              w_free_found;
    logic [SLOT_W-1:0] w_free_idx;
    logic [SLOT_W-1:0] w_slot;
    t_node             n_grp [TICK_GROUPS];
    logic              n_allow;
    t_node             w_pick;
    logic              w_grant;
    logic              w_issue;
    logic              w_push;
    logic              w_rpop;
    t_result           w_res;

    always_comb begin
        w_match_found = 1'b0;
        w_match_idx   = '0;
        w_free_found  = 1'b0;
        w_free_idx    = '0;
        for (int i = MAX_THREADS - 1; i >= 0; i--) begin
            if (r_used[i] && (r_key[i] == i_cmd.key)) begin
                w_match_found = 1'b1;
                w_match_idx   = SLOT_W'(i);
            end
            if (!r_used[i]) begin
                w_free_found = 1'b1;
                w_free_idx   = SLOT_W'(i);
            end
        end
        w_slot = w_match_found ? w_match_idx : w_free_idx;
    end

    always_comb begin
        t_node acc;
        t_node leaf;
        logic  any_busy;
        logic  any_run;
        any_busy = 1'b0;
        any_run  = 1'b0;
        for (int i = 0; i < MAX_THREADS; i++) begin
            if (r_used[i] && (r_run[i] != RUN_WAITING)) begin
                any_busy = 1'b1;
            end
            if (r_used[i] && (r_run[i] == RUN_RUNNING)) begin
                any_run = 1'b1;
            end
        end
        case (i_cfg.sync_mode)
            SYNC_ALWAYS:   n_allow = 1'b1;
            SYNC_ALL_WAIT: n_allow = !any_busy;
            SYNC_NONE_RUN: n_allow = !any_run;
            default:       n_allow = 1'b0;
        endcase
        for (int g = 0; g < TICK_GROUPS; g++) begin
            acc = '0;
            for (int j = 0; j < GROUP_SIZE; j++) begin
                if (g * GROUP_SIZE + j < MAX_THREADS) begin
                    leaf.valid = r_used[g * GROUP_SIZE + j]
                                 && (r_run[g * GROUP_SIZE + j] == RUN_WAITING);
                    leaf.idx   = SLOT_W'(g * GROUP_SIZE + j);
                    leaf.key   = {i_cfg.gen_first ? ~r_gen[g * GROUP_SIZE + j]
                                                  : {GEN_W{1'b0}},
                                  i_cfg.ign_prio ? {PRIO_W{1'b0}}
                                                 : r_prio[g * GROUP_SIZE + j]};
                    acc = sel_combine(acc, leaf, i_cfg.ign_prio);
                end
            end
            n_grp[g] = acc;
        end
    end

    always_comb begin
        t_node acc;
        acc = '0;
        for (int g = 0; g < TICK_GROUPS; g++) begin
            acc = sel_combine(acc, r_grp[g], i_cfg.ign_prio);
        end
        w_pick  = acc;
        w_grant = acc.valid && r_allow;
    end

    always_comb begin
        w_issue   = (r_state == S_IDLE) && i_cmd_valid && (r_rcount < CNT_W'(RESQ_DEPTH));
        w_push    = 1'b0;
        o_cmd_pop = 1'b0;
        w_res     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_issue && (i_cmd.op != OP_TICK)) begin
                    w_push    = 1'b1;
                    o_cmd_pop = 1'b1;
                    case (i_cmd.op)
                        OP_CREATE: begin
                            if (!w_match_found && !w_free_found) begin
                                w_res.status = STATUS_FULL;
                            end
                        end
                        OP_BLOCK, OP_RESUME, OP_REMOVE: begin
                            if (!w_match_found) begin
                                w_res.status = STATUS_UNTRACKED;
                            end
                        end
                        OP_QUERY: begin
                            if (w_match_found) begin
                                w_res.priority_out = POUT_W'(r_prio[w_match_idx]);
                            end else begin
                                w_res.priority_out = '1;
                                w_res.status       = STATUS_UNTRACKED;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_TICK: begin
                w_push    = 1'b1;
                o_cmd_pop = 1'b1;
                if (w_grant) begin
                    w_res.grant_valid = 1'b1;
                    w_res.grant_key   = r_key[w_pick.idx];
                end
            end
            default: begin
            end
        endcase
    end

    assign w_rpop  = i_pop && (r_rcount != '0);
    assign o_empty = (r_rcount == '0);
    assign o_res   = r_rq[r_rrd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rwr    <= '0;
            r_rrd    <= '0;
            r_rcount <= '0;
            for (int i = 0; i < MAX_THREADS; i++) begin
                r_used[i] <= 1'b0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_issue) begin
                        case (i_cmd.op)
                            OP_CREATE: begin
                                if (w_match_found || w_free_found) begin
                                    r_used[w_slot] <= 1'b1;
                                    r_key[w_slot]  <= i_cmd.key;
                                    r_run[w_slot]  <= RUN_RUNNING;
                                    r_prio[w_slot] <= i_cmd.prio;
                                    r_gen[w_slot]  <= '0;
                                end
                            end
                            OP_BLOCK: begin
                                if (w_match_found) begin
                                    r_run[w_match_idx] <= RUN_WAITING;
                                end
                            end
                            OP_RESUME: begin
                                if (w_match_found) begin
                                    r_run[w_match_idx] <= RUN_RUNNING;
                                end
                            end
                            OP_REMOVE: begin
                                if (w_match_found) begin
                                    r_used[w_match_idx] <= 1'b0;
                                end
                            end
                            OP_TICK: begin
                                r_grp   <= n_grp;
                                r_allow <= n_allow;
                                r_state <= S_TICK;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_TICK: begin
                    if (w_grant) begin
                        r_run[w_pick.idx] <= RUN_READY;
                        if (r_gen[w_pick.idx] != '1) begin
                            r_gen[w_pick.idx] <= r_gen[w_pick.idx] + 1'b1;
                        end
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (w_push) begin
                r_rq[r_rwr] <= w_res;
                r_rwr <= (r_rwr == PTR_W'(RESQ_DEPTH - 1)) ? '0 : r_rwr + 1'b1;
            end
            if (w_rpop) begin
                r_rrd <= (r_rrd == PTR_W'(RESQ_DEPTH - 1)) ? '0 : r_rrd + 1'b1;
            end
            r_rcount <= r_rcount + CNT_W'(w_push) - CNT_W'(w_rpop);
        end
    end

`ifndef ASSERT_OFF
    a_resq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rcount <= CNT_W'(RESQ_DEPTH))
        else $error("result queue count above its depth");

    a_tick_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK) |=> (r_state == S_IDLE))
        else $error("tick selection held longer than one step");

    a_grant_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_TICK) && w_grant) |->
            (r_used[w_pick.idx] && (r_run[w_pick.idx] == RUN_WAITING)))
        else $error("grant of a slot that is not a waiting entry");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (i_cmd_valid && w_push))
        else $error("command taken without a result beat");
`endif

endmodule

>>> sv/priority_thread_release_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_thread_release_scheduler: thread table with prioritized release
// Tracks up to sixteen threads and releases at most one waiting thread per tick,
// chosen by priority or generation, under the configured sync condition.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Beat
// request   in         push / full          req_type, thread_key, new_priority
// result    out        empty / pop          grant_valid, grant_key, priority_out, status
// config    in         i_cfg_we             i_cfg_index, i_cfg_wdata
//
// A request is held in the command queue, then carried out in the table
// (for a tick the slots are first reduced in four groups, then across groups).
// Every request gives exactly one result beat, queued two deep.
// Reset clears all slots at once; there is no clearing pass.
// full rises when the two-entry command queue is full; the table stalls
// while the result queue is full.
// ----------------------------------------------------------------------------
module priority_thread_release_scheduler (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [prts_pkg::REQ_W-1:0]           i_req_type,
    input  logic [prts_pkg::KEY_W-1:0]           i_thread_key,
    input  logic [prts_pkg::PRIO_W-1:0]          i_new_priority,
    output logic                                 empty,
    input  logic                                 pop,
    output logic                                 o_grant_valid,
    output logic [prts_pkg::KEY_W-1:0]           o_grant_key,
    output logic signed [prts_pkg::POUT_W-1:0]   o_priority_out,
    output logic [prts_pkg::STAT_W-1:0]          o_status,
    input  logic                                 i_cfg_we,
    input  logic [prts_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [prts_pkg::CFG_W-1:0]           i_cfg_wdata
);
    import prts_pkg::*;

    t_cfg    r_cfg;
    t_cmd    w_cmd;
    logic    w_cmd_valid;
    logic    w_cmd_pop;
    t_result w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gen_first <= 1'b0;
            r_cfg.sync_mode <= SYNC_NONE_RUN;
            r_cfg.ign_prio  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GEN_FIRST:   r_cfg.gen_first <= i_cfg_wdata[0];
                CFG_SYNC_MODE:   r_cfg.sync_mode <= i_cfg_wdata[1:0];
                CFG_IGNORE_PRIO: r_cfg.ign_prio  <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    prts_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_req_type     (i_req_type),
        .i_thread_key   (i_thread_key),
        .i_new_priority (i_new_priority),
        .o_cmd_valid    (w_cmd_valid),
        .o_cmd          (w_cmd),
        .i_cmd_pop      (w_cmd_pop)
    );

    prts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_res       (w_res)
    );

    assign o_grant_valid  = w_res.grant_valid;
    assign o_grant_key    = w_res.grant_key;
    assign o_priority_out = w_res.priority_out;
    assign o_status       = w_res.status;

endmodule
